// ----- hdl/apgmg_pkg.sv -----
package apgmg_pkg;

  localparam int MAX_ORDER_DEF = 61;

  localparam int ORDER_W    = 6;
  localparam int COUNT_W    = 12;
  localparam int GROUP_W    = 12;
  localparam int ID_W       = 12;
  localparam int CMP_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_ORDER   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 1'd1;

  localparam logic [ORDER_W-1:0] PLANE_ORDER_RST   = 6'd5;
  localparam logic [COUNT_W-1:0] ELEMENT_COUNT_RST = 12'd25;

  typedef enum logic [1:0] {
    KIND_ROW,
    KIND_COL,
    KIND_SLOPE
  } kind_t;

  typedef struct packed {
    logic load;
    logic check;
    logic emit_bad;
    logic div_step;
    logic walk_init;
    logic walk_step;
    logic flush;
  } apgmg_cmd_t;

  typedef struct packed {
    logic bad;
    logic is_slope;
    logic div_done;
    logic walk_end;
  } apgmg_stat_t;

endpackage

// ----- hdl/apgmg_ctrl.sv -----
module apgmg_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  apgmg_pkg::apgmg_stat_t  stat,
  output apgmg_pkg::apgmg_cmd_t   cmd
);
  import apgmg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_INIT,
    S_WALK,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.bad) begin
          cmd.emit_bad = 1'b1;
          state_nxt    = S_IDLE;
        end else if (stat.is_slope) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_INIT;
        end
      end
      S_DIV: begin
        // repeated subtraction splits the offset into slope and base
        if (stat.div_done) begin
          state_nxt = S_INIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_INIT: begin
        cmd.walk_init = 1'b1;
        state_nxt     = S_WALK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_end) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// ----- hdl/apgmg_datapath.sv -----
module apgmg_datapath #(
  parameter int MAX_ORDER = apgmg_pkg::MAX_ORDER_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [apgmg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [apgmg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [apgmg_pkg::GROUP_W-1:0]      group_index,
  input  apgmg_pkg::apgmg_cmd_t              cmd,
  output apgmg_pkg::apgmg_stat_t             stat,
  output logic                               out_valid,
  output logic [apgmg_pkg::ID_W-1:0]         out_element_id,
  output logic                               out_present,
  output logic                               out_last_of_group,
  output logic                               out_bad_index
);
  import apgmg_pkg::*;

  localparam int OW = $clog2(MAX_ORDER + 1);
  localparam logic [OW-1:0]      MAX_P     = OW'(MAX_ORDER);
  localparam logic [ORDER_W-1:0] MAX_P_CFG = ORDER_W'(MAX_ORDER);

  logic [ORDER_W-1:0] plane_order_r;
  logic [COUNT_W-1:0] element_count_r;

  logic [GROUP_W-1:0] g_r;
  logic [OW-1:0]      p_r;
  logic [GROUP_W-1:0] t_r;
  logic [OW-1:0]      k_r;
  kind_t              kind_r;
  logic [ID_W-1:0]    base_r;
  logic [OW:0]        rr_r;
  logic [OW-1:0]      j_r;
  logic               pend_vld_r;
  logic [ID_W-1:0]    pend_id_r;

  logic               out_valid_r;
  logic [ID_W-1:0]    out_id_r;
  logic               out_present_r;
  logic               out_last_r;
  logic               out_bad_r;

  logic [OW-1:0]      p_sat;
  logic [2*OW-1:0]    p_sq;
  logic [CMP_W-1:0]   limit;
  logic [OW:0]        two_p;
  logic               is_col;
  logic               is_slope;
  logic               bad;
  logic [ID_W-1:0]    id_cur;
  logic               id_ok;
  logic               j_last;
  logic [OW:0]        rr_sum;
  logic [OW:0]        rr_mod;
  logic [OW:0]        rr_step;
  logic [ID_W-1:0]    base_step;
  logic [ID_W-1:0]    row_base;

  assign p_sat = (plane_order_r > MAX_P_CFG) ? MAX_P : plane_order_r[OW-1:0];

  assign p_sq     = (2*OW)'(p_r) * (2*OW)'(p_r);
  assign limit    = CMP_W'(p_sq) + CMP_W'(p_r);
  assign two_p    = {p_r, 1'b0};
  assign is_col   = (g_r >= GROUP_W'(p_r));
  assign is_slope = (g_r >= GROUP_W'(two_p));
  assign bad      = (p_r == '0) || (CMP_W'(g_r) >= limit);

  assign id_cur = base_r + ID_W'(rr_r);
  assign id_ok  = (id_cur < element_count_r);
  assign j_last = (j_r == (p_r - OW'(1)));

  // (r + k*j) mod p kept incrementally; k < p so one subtract is enough
  assign rr_sum = rr_r + (OW+1)'(k_r);
  assign rr_mod = (rr_sum >= (OW+1)'(p_r)) ? (rr_sum - (OW+1)'(p_r)) : rr_sum;

  assign row_base = ID_W'(t_r[OW-1:0]) * ID_W'(p_r);

  always_comb begin
    unique case (kind_r)
      KIND_ROW: begin
        rr_step   = rr_r + (OW+1)'(1);
        base_step = base_r;
      end
      KIND_COL: begin
        rr_step   = rr_r;
        base_step = base_r + ID_W'(p_r);
      end
      KIND_SLOPE: begin
        rr_step   = rr_mod;
        base_step = base_r + ID_W'(p_r);
      end
      default: begin
        rr_step   = rr_r;
        base_step = base_r;
      end
    endcase
  end

  always_comb begin
    stat          = '0;
    stat.bad      = bad;
    stat.is_slope = is_slope;
    stat.div_done = (t_r < GROUP_W'(p_r));
    // ids grow with j, so the first dropped id ends the group
    stat.walk_end = j_last || !id_ok;
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_order_r   <= PLANE_ORDER_RST;
      element_count_r <= ELEMENT_COUNT_RST;
      out_valid_r     <= 1'b0;
      pend_vld_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PLANE_ORDER:   plane_order_r   <= cfg_wdata[ORDER_W-1:0];
          CFG_ELEMENT_COUNT: element_count_r <= cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      out_valid_r <= cmd.emit_bad || cmd.flush || (cmd.walk_step && id_ok && pend_vld_r);
      if (cmd.walk_init) begin
        pend_vld_r <= 1'b0;
      end else if (cmd.walk_step && id_ok) begin
        pend_vld_r <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      g_r <= group_index;
      p_r <= p_sat;
    end
    if (cmd.check) begin
      k_r <= OW'(1);
      if (is_slope) begin
        kind_r <= KIND_SLOPE;
        t_r    <= g_r - GROUP_W'(two_p);
      end else if (is_col) begin
        kind_r <= KIND_COL;
        t_r    <= g_r - GROUP_W'(p_r);
      end else begin
        kind_r <= KIND_ROW;
        t_r    <= g_r;
      end
    end
    if (cmd.div_step) begin
      t_r <= t_r - GROUP_W'(p_r);
      k_r <= k_r + OW'(1);
    end
    if (cmd.walk_init) begin
      j_r <= '0;
      if (kind_r == KIND_ROW) begin
        base_r <= row_base;
        rr_r   <= '0;
      end else begin
        base_r <= '0;
        rr_r   <= {1'b0, t_r[OW-1:0]};
      end
    end
    if (cmd.walk_step) begin
      j_r    <= j_r + OW'(1);
      base_r <= base_step;
      rr_r   <= rr_step;
      if (id_ok) begin
        pend_id_r <= id_cur;
      end
    end

    // held back one member so the last one can be marked
    if (cmd.emit_bad) begin
      out_id_r      <= '0;
      out_present_r <= 1'b0;
      out_last_r    <= 1'b1;
      out_bad_r     <= 1'b1;
    end else if (cmd.flush) begin
      out_id_r      <= pend_vld_r ? pend_id_r : '0;
      out_present_r <= pend_vld_r;
      out_last_r    <= 1'b1;
      out_bad_r     <= 1'b0;
    end else if (cmd.walk_step && id_ok && pend_vld_r) begin
      out_id_r      <= pend_id_r;
      out_present_r <= 1'b1;
      out_last_r    <= 1'b0;
      out_bad_r     <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_element_id    = out_id_r;
  assign out_present       = out_present_r;
  assign out_last_of_group = out_last_r;
  assign out_bad_index     = out_bad_r;

endmodule

// ----- hdl/affine_plane_group_member_generator_core.sv -----
// Emits the members of one line of an affine plane of prime order p on a one-cycle
// out_valid strobe, one result per cycle while the members are walked; the receiver cannot
// stall, so every strobe must be taken. An item is taken when start is high and busy is
// low; busy stays high until the final result (out_last_of_group) has been issued. Sloped
// lines first get their slope and base from a repeated-subtraction loop, one subtract per
// cycle; the member walk then produces one id per cycle over at most p members. A bad index
// or an empty group gives a single result with present low. The user must write registers
// through cfg_* only while busy is low; the block itself does not enforce this.
module affine_plane_group_member_generator_core #(
  parameter int MAX_ORDER = apgmg_pkg::MAX_ORDER_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [apgmg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [apgmg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                               start,
  output logic                               busy,
  input  logic [apgmg_pkg::GROUP_W-1:0]      in_group_index,
  output logic                               out_valid,
  output logic [apgmg_pkg::ID_W-1:0]         out_element_id,
  output logic                               out_present,
  output logic                               out_last_of_group,
  output logic                               out_bad_index
);
  import apgmg_pkg::*;

  apgmg_cmd_t  cmd;
  apgmg_stat_t stat;

  apgmg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  apgmg_datapath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .group_index       (in_group_index),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_element_id    (out_element_id),
    .out_present       (out_present),
    .out_last_of_group (out_last_of_group),
    .out_bad_index     (out_bad_index)
  );

endmodule
